/* design/ffpa_pkg.sv */
// Package for the first-fit pool allocator.
// Holds operation and status codes, widths and the scan packet type.
// No dependencies.
`default_nettype none
package ffpa_pkg;

   // Default sizes of the pool and of the block table.
   localparam int unsigned POOL_BYTES_DEF    = 65536;
   localparam int unsigned TABLE_ENTRIES_DEF = 64;

   // Widths of the port fields.
   localparam int unsigned KIND_W   = 3;
   localparam int unsigned REQ_W    = 17;
   localparam int unsigned HANDLE_W = 17;
   localparam int unsigned OFS_W    = 16;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned STATUS_W = 3;

   // Internal width of bases and sizes; covers pools up to 1 MiB plus a rounded request.
   localparam int unsigned ADDR_W = 21;

   // Operation codes.
   localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 3'd2;
   localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_POOL_FULL  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OOB        = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd4;

   // Packet that travels down the chain of table cells.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] size;      // rounded allocation size
      logic [ADDR_W-1:0] handle;    // base address being looked for
      logic [ADDR_W-1:0] bump;      // append address for a new entry
      logic              fits;      // pool has room for an appended entry
      logic              hit;       // an existing entry has taken the operation
      logic              appended;  // a new entry has been written
      logic [ADDR_W-1:0] hit_base;
      logic [ADDR_W-1:0] hit_size;
   } pkt_type;

endpackage
`default_nettype wire

/* design/ffpa_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module ffpa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One access per cycle: a write, or a read; the data read, also on a write, is registered.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule
`default_nettype wire

/* design/ffpa_cell.sv */
// One entry of the block table, held in a cell of the scan chain.
// Depends on ffpa_pkg.
`default_nettype none
module ffpa_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             pkt_vld_in,
   input  wire ffpa_pkg::pkt_type pkt_in,
   output logic                  pkt_vld_out,
   output ffpa_pkg::pkt_type     pkt_out
);

   logic                           valid_ff, valid_in;
   logic                           used_ff, used_in;
   logic [ffpa_pkg::ADDR_W-1:0]    base_ff, base_in;
   logic [ffpa_pkg::ADDR_W-1:0]    size_ff, size_in;
   logic                           pkt_vld_ff;
   ffpa_pkg::pkt_type              pkt_ff, pkt_nx_in;
   logic                           base_match;

   assign base_match = valid_ff && (base_ff == pkt_in.handle);

   // The first cell that can serve the operation marks the packet as taken.
   always_comb begin
      valid_in  = valid_ff;
      used_in   = used_ff;
      base_in   = base_ff;
      size_in   = size_ff;
      pkt_nx_in = pkt_in;
      if (pkt_vld_in && !pkt_in.hit && !pkt_in.appended) begin
         case (pkt_in.kind)
            ffpa_pkg::KIND_ALLOC: begin
               if (valid_ff && !used_ff && (size_ff >= pkt_in.size)) begin
                  used_in            = 1'b1;
                  pkt_nx_in.hit      = 1'b1;
                  pkt_nx_in.hit_base = base_ff;
                  pkt_nx_in.hit_size = size_ff;
               end else if (!valid_ff && pkt_in.fits) begin
                  // First empty cell: append a new entry at the bump offset.
                  valid_in           = 1'b1;
                  used_in            = 1'b1;
                  base_in            = pkt_in.bump;
                  size_in            = pkt_in.size;
                  pkt_nx_in.appended = 1'b1;
                  pkt_nx_in.hit_base = pkt_in.bump;
                  pkt_nx_in.hit_size = pkt_in.size;
               end
            end
            ffpa_pkg::KIND_FREE: begin
               if (base_match) begin
                  used_in       = 1'b0;
                  pkt_nx_in.hit = 1'b1;
               end
            end
            ffpa_pkg::KIND_QUERY, ffpa_pkg::KIND_WRITE, ffpa_pkg::KIND_READ: begin
               if (base_match && used_ff) begin
                  pkt_nx_in.hit      = 1'b1;
                  pkt_nx_in.hit_base = base_ff;
                  pkt_nx_in.hit_size = size_ff;
               end
            end
            default: begin
               pkt_nx_in = pkt_in;
            end
         endcase
      end
   end

   // Entry state and the packet stage towards the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         used_ff    <= 1'b0;
         pkt_vld_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         used_ff    <= used_in;
         pkt_vld_ff <= pkt_vld_in;
      end
      base_ff <= base_in;
      size_ff <= size_in;
      pkt_ff  <= pkt_nx_in;
   end

   assign pkt_vld_out = pkt_vld_ff;
   assign pkt_out     = pkt_ff;

endmodule
`default_nettype wire

/* design/first_fit_pool_allocator.sv */
// First-fit pool allocator. After reset the block clears its byte pool, one byte a cycle,
// and takes no operation until that pass is done. Each operation then travels once down a
// chain of TABLE_ENTRIES table cells, one cell a cycle, before its result is offered. A word
// write or read then goes through the pool one byte at a time, as the pool is one byte-wide
// memory port. One operation is in flight at a time: the next is taken only after the result
// has been taken.
// Depends on ffpa_pkg, ffpa_cell and ffpa_ram.
`default_nettype none
module first_fit_pool_allocator #(
   parameter int unsigned POOL_BYTES    = ffpa_pkg::POOL_BYTES_DEF,
   parameter int unsigned TABLE_ENTRIES = ffpa_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [ffpa_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [ffpa_pkg::REQ_W-1:0]        req_request_size,
   input  wire logic [ffpa_pkg::HANDLE_W-1:0]     req_handle,
   input  wire logic [ffpa_pkg::OFS_W-1:0]        req_byte_offset,
   input  wire logic signed [ffpa_pkg::DATA_W-1:0] req_write_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [ffpa_pkg::STATUS_W-1:0]          rsp_status,
   output logic [ffpa_pkg::HANDLE_W-1:0]          rsp_block_address,
   output logic signed [ffpa_pkg::DATA_W-1:0]     rsp_read_data
);

   localparam int unsigned AW = $clog2(POOL_BYTES);
   localparam int unsigned W  = ffpa_pkg::ADDR_W;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_MEM, S_RESP
   } state_type;

   state_type                        state_ff;
   logic [AW-1:0]                    clr_ff;
   logic [W-1:0]                     bump_ff;
   logic [ffpa_pkg::KIND_W-1:0]      kind_ff;
   logic [ffpa_pkg::DATA_W-1:0]      wdata_ff;
   logic [W-1:0]                     acc_addr_ff;
   logic [2:0]                       cnt_ff;
   logic                             launch_vld_ff;
   ffpa_pkg::pkt_type                launch_ff;
   logic [ffpa_pkg::STATUS_W-1:0]    status_ff;
   logic [ffpa_pkg::HANDLE_W-1:0]    baddr_ff;
   logic [ffpa_pkg::DATA_W-1:0]      rdata_ff;

   logic                             chain_vld [TABLE_ENTRIES+1];
   ffpa_pkg::pkt_type                chain_pkt [TABLE_ENTRIES+1];
   ffpa_pkg::pkt_type                tail;
   logic                             tail_vld;

   logic [W-1:0]                     size_rnd;
   logic [W:0]                       bump_end;
   logic [W-1:0]                     word_end;
   logic [1:0]                       byte_sel;
   logic                             ram_we;
   logic [AW-1:0]                    ram_addr;
   logic [7:0]                       ram_wdata;
   logic [7:0]                       ram_rdata;
   logic                             req_xfer;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // Round the request up to a multiple of 16 bytes and check it against the pool end.
   assign size_rnd = (W'(req_request_size) + W'(15)) & ~W'(15);
   assign bump_end = {1'b0, bump_ff} + {1'b0, size_rnd};

   // Chain of table cells.
   assign chain_vld[0] = launch_vld_ff;
   assign chain_pkt[0] = launch_ff;
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      ffpa_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .pkt_vld_in  (chain_vld[g]),
         .pkt_in      (chain_pkt[g]),
         .pkt_vld_out (chain_vld[g+1]),
         .pkt_out     (chain_pkt[g+1])
      );
   end
   assign tail_vld = chain_vld[TABLE_ENTRIES];
   assign tail     = chain_pkt[TABLE_ENTRIES];

   // While the scan runs, the access address still holds the byte offset of the word.
   assign word_end = acc_addr_ff;

   // Pool memory port: clearing pass, or one byte of the word a cycle.
   assign byte_sel  = 2'(cnt_ff - 3'd1);
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = AW'(acc_addr_ff + W'(cnt_ff));
      ram_wdata = wdata_ff[8*cnt_ff[1:0] +: 8];
      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_addr  = clr_ff;
            ram_wdata = 8'd0;
         end
         S_MEM: begin
            ram_we = (kind_ff == ffpa_pkg::KIND_WRITE);
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   ffpa_ram #(.WIDTH(8), .DEPTH(POOL_BYTES)) u_pool (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Sequencer: clear the pool, launch, collect the scan result, access the pool, present the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         bump_ff       <= '0;
         launch_vld_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         launch_vld_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(POOL_BYTES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_xfer) begin
                  launch_vld_ff      <= 1'b1;
                  launch_ff.kind     <= req_kind;
                  launch_ff.size     <= size_rnd;
                  launch_ff.handle   <= W'(req_handle);
                  launch_ff.bump     <= bump_ff;
                  launch_ff.fits     <= (bump_end <= (W+1)'(POOL_BYTES));
                  launch_ff.hit      <= 1'b0;
                  launch_ff.appended <= 1'b0;
                  launch_ff.hit_base <= '0;
                  launch_ff.hit_size <= '0;
                  kind_ff            <= req_kind;
                  wdata_ff           <= req_write_data;
                  acc_addr_ff        <= W'(req_byte_offset);
                  status_ff          <= ffpa_pkg::ST_OK;
                  baddr_ff           <= '0;
                  rdata_ff           <= '0;
                  state_ff           <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (tail_vld) begin
                  state_ff <= S_RESP;
                  case (tail.kind)
                     ffpa_pkg::KIND_ALLOC: begin
                        if (tail.hit || tail.appended) begin
                           baddr_ff <= tail.hit_base[ffpa_pkg::HANDLE_W-1:0];
                        end else if (!tail.fits) begin
                           status_ff <= ffpa_pkg::ST_POOL_FULL;
                        end else begin
                           status_ff <= ffpa_pkg::ST_TABLE_FULL;
                        end
                        if (tail.appended) begin
                           bump_ff <= bump_ff + tail.size;
                        end
                     end
                     ffpa_pkg::KIND_FREE, ffpa_pkg::KIND_QUERY: begin
                        if (!tail.hit) begin
                           status_ff <= ffpa_pkg::ST_BAD_HANDLE;
                        end
                     end
                     ffpa_pkg::KIND_WRITE, ffpa_pkg::KIND_READ: begin
                        if (!tail.hit) begin
                           status_ff <= ffpa_pkg::ST_BAD_HANDLE;
                        end else if ((word_end + W'(4)) > tail.hit_size) begin
                           status_ff <= ffpa_pkg::ST_OOB;
                        end else begin
                           acc_addr_ff <= tail.hit_base + acc_addr_ff;
                           cnt_ff      <= '0;
                           state_ff    <= S_MEM;
                        end
                     end
                     default: begin
                        status_ff <= ffpa_pkg::ST_OK;
                     end
                  endcase
               end
            end
            S_MEM: begin
               cnt_ff <= cnt_ff + 3'd1;
               if (kind_ff == ffpa_pkg::KIND_WRITE) begin
                  if (cnt_ff == 3'd3) begin
                     state_ff <= S_RESP;
                  end
               end else begin
                  // Read data is registered, so it arrives in the cycle after its address.
                  if (cnt_ff != 3'd0) begin
                     rdata_ff[8*byte_sel +: 8] <= ram_rdata;
                  end
                  if (cnt_ff == 3'd4) begin
                     state_ff <= S_RESP;
                  end
               end
            end
            S_RESP: begin
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = (state_ff == S_RESP);
   assign rsp_status        = status_ff;
   assign rsp_block_address = baddr_ff;
   assign rsp_read_data     = rdata_ff;

   // The block never offers a result while it takes an operation.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request and result open together");

   // The bump offset never runs past the end of the pool.
   a_bump_bound: assert property (@(posedge clock) disable iff (reset)
      bump_ff <= W'(POOL_BYTES)) else $error("bump offset beyond pool");

   // A packet leaves the chain only while the sequencer waits for it.
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail_vld |-> state_ff == S_SCAN) else $error("scan result outside scan");

   // A transfer always launches exactly one packet into the chain.
   a_launch: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> launch_vld_ff && state_ff == S_SCAN) else $error("launch missing");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the first-fit pool allocator.
// Drives operations on valid/ready and predicts each result with its own table and pool copy.
// Depends on ffpa_pkg and first_fit_pool_allocator.
`timescale 1ns / 100ps
module tb;

   localparam int unsigned POOL_SZ = 65536;
   localparam int unsigned SLOTS   = 64;

   typedef struct {
      logic [ffpa_pkg::STATUS_W-1:0]      status;
      logic [ffpa_pkg::HANDLE_W-1:0]      addr;
      logic signed [ffpa_pkg::DATA_W-1:0] rdata;
   } outcome_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [ffpa_pkg::KIND_W-1:0]         req_kind;
   logic [ffpa_pkg::REQ_W-1:0]          req_request_size;
   logic [ffpa_pkg::HANDLE_W-1:0]       req_handle;
   logic [ffpa_pkg::OFS_W-1:0]          req_byte_offset;
   logic signed [ffpa_pkg::DATA_W-1:0]  req_write_data;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [ffpa_pkg::STATUS_W-1:0]       rsp_status;
   logic [ffpa_pkg::HANDLE_W-1:0]       rsp_block_address;
   logic signed [ffpa_pkg::DATA_W-1:0]  rsp_read_data;

   // Predicted allocator state.
   int unsigned blk_base [SLOTS];
   int unsigned blk_size [SLOTS];
   bit          blk_used [SLOTS];
   int unsigned blk_count;
   int unsigned bump_ptr;
   byte unsigned pool_mem [POOL_SZ];

   outcome_type pending_q[$];
   int          mismatches;
   int          status_seen [8];
   int          results_seen;
   bit          idle_on;
   int          hold_left;

   first_fit_pool_allocator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_request_size(req_request_size), .req_handle(req_handle),
      .req_byte_offset(req_byte_offset), .req_write_data(req_write_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_block_address(rsp_block_address), .rsp_read_data(rsp_read_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // First entry with a matching base, optionally one that is in use; -1 if none.
   function automatic int find_block(int unsigned base, bit need_used);
      for (int i = 0; i < blk_count; i++) begin
         if (blk_base[i] == base && (!need_used || blk_used[i])) return i;
      end
      return -1;
   endfunction

   // Works out the result of one operation and updates the predicted state.
   function automatic outcome_type allocator_step(logic [ffpa_pkg::KIND_W-1:0] kind,
                                                  int unsigned rq, int unsigned hnd,
                                                  int unsigned ofs, logic [31:0] wd);
      outcome_type res;
      int unsigned sz;
      int          hit;
      int unsigned a;
      res.status = ffpa_pkg::ST_OK;
      res.addr   = '0;
      res.rdata  = '0;
      hit = -1;
      case (kind)
         ffpa_pkg::KIND_ALLOC: begin
            sz = (rq + 15) & ~32'd15;
            for (int i = 0; i < blk_count; i++) begin
               if (!blk_used[i] && blk_size[i] >= sz) begin
                  hit = i;
                  break;
               end
            end
            if (hit >= 0) begin
               blk_used[hit] = 1'b1;
               res.addr = ffpa_pkg::HANDLE_W'(blk_base[hit]);
            end else if (bump_ptr + sz > POOL_SZ) begin
               res.status = ffpa_pkg::ST_POOL_FULL;
            end else if (blk_count >= SLOTS) begin
               res.status = ffpa_pkg::ST_TABLE_FULL;
            end else begin
               blk_base[blk_count] = bump_ptr;
               blk_size[blk_count] = sz;
               blk_used[blk_count] = 1'b1;
               blk_count++;
               res.addr = ffpa_pkg::HANDLE_W'(bump_ptr);
               bump_ptr += sz;
            end
         end
         ffpa_pkg::KIND_FREE: begin
            hit = find_block(hnd, 1'b0);
            if (hit >= 0) blk_used[hit] = 1'b0;
            else res.status = ffpa_pkg::ST_BAD_HANDLE;
         end
         ffpa_pkg::KIND_QUERY: begin
            if (find_block(hnd, 1'b1) < 0) res.status = ffpa_pkg::ST_BAD_HANDLE;
         end
         ffpa_pkg::KIND_WRITE, ffpa_pkg::KIND_READ: begin
            hit = find_block(hnd, 1'b1);
            if (hit < 0) begin
               res.status = ffpa_pkg::ST_BAD_HANDLE;
            end else if (ofs + 4 > blk_size[hit]) begin
               res.status = ffpa_pkg::ST_OOB;
            end else begin
               a = blk_base[hit] + ofs;
               for (int i = 0; i < 4; i++) begin
                  if (kind == ffpa_pkg::KIND_WRITE) pool_mem[(a + i) % POOL_SZ] = wd[8*i +: 8];
                  else res.rdata[8*i +: 8] = pool_mem[(a + i) % POOL_SZ];
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // Sends one operation; the prediction is made at the edge where it transfers.
   task automatic send_op(input logic [ffpa_pkg::KIND_W-1:0] kind, input int unsigned rq,
                          input int unsigned hnd, input int unsigned ofs, input logic [31:0] wd);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_kind         = kind;
      req_request_size = ffpa_pkg::REQ_W'(rq);
      req_handle       = ffpa_pkg::HANDLE_W'(hnd);
      req_byte_offset  = ffpa_pkg::OFS_W'(ofs);
      req_write_data   = wd;
      req_valid        = 1'b1;
      // Ready only changes at rising edges, so it is settled at the falling edge.
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      pending_q.push_back(allocator_step(kind, rq, hnd, ofs, wd));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Pauses the sender until every expected result has come back.
   task automatic wait_drained();
      wait (pending_q.size() == 0);
      @(negedge clock);
   endtask

   // Handle of a known block most of the time, otherwise any address from 0 up to and including POOL_SZ.
   function automatic int unsigned pick_handle();
      if (blk_count > 0 && $urandom_range(0, 9) < 8)
         return blk_base[$urandom_range(0, blk_count - 1)];
      if ($urandom_range(0, 7) == 0) return POOL_SZ;
      return $urandom_range(0, POOL_SZ);
   endfunction

   function automatic int unsigned pick_offset(int unsigned hnd);
      int e;
      e = find_block(hnd, 1'b1);
      if (e >= 0 && $urandom_range(0, 9) < 8) begin
         if (blk_size[e] >= 4 && $urandom_range(0, 3) != 0)
            return $urandom_range(0, blk_size[e] - 4);
         return $urandom_range(0, blk_size[e] + 4) & 16'hFFFF;
      end
      return $urandom_range(0, 16'hFFFF);
   endfunction

   // Directed cases: size extremes, reuse, duplicate bases, bounds and bad handles.
   task automatic test_directed();
      send_op(ffpa_pkg::KIND_ALLOC, 0, 0, 0, 0);                // zero-size entry at 0
      send_op(ffpa_pkg::KIND_ALLOC, 1, 0, 0, 0);                // second entry, also base 0
      send_op(ffpa_pkg::KIND_ALLOC, POOL_SZ + 1, 0, 0, 0);      // pool cannot take it
      send_op(ffpa_pkg::KIND_ALLOC, 33, 0, 0, 0);               // 48 bytes at 16
      send_op(ffpa_pkg::KIND_WRITE, 0, 16, 0, 32'h8000_0001);
      send_op(ffpa_pkg::KIND_READ, 0, 16, 0, 0);
      send_op(ffpa_pkg::KIND_WRITE, 0, 16, 44, 32'h7FFF_FFFF);  // last word of the block
      send_op(ffpa_pkg::KIND_READ, 0, 16, 44, 0);
      send_op(ffpa_pkg::KIND_WRITE, 0, 16, 45, 32'hFFFF_FFFF);  // one byte past the end
      send_op(ffpa_pkg::KIND_READ, 0, 16, 16'hFFFF, 0);
      send_op(ffpa_pkg::KIND_WRITE, 0, 0, 0, 32'h1234_5678);    // zero-size block hit first
      send_op(ffpa_pkg::KIND_FREE, 0, 0, 0, 0);
      send_op(ffpa_pkg::KIND_QUERY, 0, 0, 0, 0);
      send_op(ffpa_pkg::KIND_FREE, 0, 0, 0, 0);                 // freeing an unused block
      send_op(ffpa_pkg::KIND_FREE, 0, 99, 0, 0);
      send_op(ffpa_pkg::KIND_QUERY, 0, 99, 0, 0);
      send_op(ffpa_pkg::KIND_READ, 0, POOL_SZ, 0, 0);
      send_op(ffpa_pkg::KIND_ALLOC, 0, 0, 0, 0);                // reuses the zero-size entry
      send_op(ffpa_pkg::KIND_FREE, 0, 16, 0, 0);
      send_op(ffpa_pkg::KIND_ALLOC, 20, 0, 0, 0);               // reuses the 48-byte block
      send_op(ffpa_pkg::KIND_READ, 0, 16, 0, 0);
      send_op(ffpa_pkg::KIND_ALLOC, POOL_SZ, 0, 0, 0);
      wait_drained();
   endtask

   // Random mix weighted towards valid handles and offsets.
   task automatic test_random(input int count);
      int unsigned k, hnd, rq;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 9);
         hnd = pick_handle();
         if ($urandom_range(0, 19) == 0) rq = $urandom_range(0, POOL_SZ);
         else rq = $urandom_range(0, 256);
         if (k < 3)
            send_op(ffpa_pkg::KIND_ALLOC, rq, hnd, $urandom_range(0, 16'hFFFF), $urandom());
         else if (k < 5) send_op(ffpa_pkg::KIND_FREE, rq, hnd, 0, $urandom());
         else if (k < 6) send_op(ffpa_pkg::KIND_QUERY, rq, hnd, 0, 0);
         else if (k < 8) send_op(ffpa_pkg::KIND_WRITE, rq, hnd, pick_offset(hnd), $urandom());
         else send_op(ffpa_pkg::KIND_READ, rq, hnd, pick_offset(hnd), $urandom());
      end
   endtask

   // Holds the result side off for a long stretch so the block stalls its input.
   task automatic test_backpressure();
      hold_left = 400;
      test_random(6);
      wait_drained();
   endtask

   // Stall bursts on the result side.
   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready = 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 11) - 1;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // Compares every result transfer with the oldest prediction.
   initial begin
      outcome_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_q.size() == 0) begin
               report_mismatch("result with no operation outstanding");
            end else begin
               want = pending_q.pop_front();
               results_seen++;
               status_seen[want.status]++;
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
               if (rsp_block_address !== want.addr)
                  report_mismatch($sformatf("block_address %0d, expected %0d",
                                            rsp_block_address, want.addr));
               if (rsp_read_data !== want.rdata)
                  report_mismatch($sformatf("read_data %0d, expected %0d",
                                            rsp_read_data, want.rdata));
            end
         end
      end
   end

   // The pool clear after reset alone writes all 65536 bytes of the pool.
   initial begin
      #20_000_000;
      $display("Timeout with %0d results outstanding.", pending_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      req_valid = 1'b0;
      req_kind = '0;
      req_request_size = '0;
      req_handle = '0;
      req_byte_offset = '0;
      req_write_data = '0;
      mismatches = 0;
      results_seen = 0;
      hold_left = 0;
      idle_on = 1'b1;
      blk_count = 0;
      bump_ptr = 0;
      foreach (pool_mem[i]) pool_mem[i] = 8'h00;
      foreach (blk_used[i]) blk_used[i] = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
      reset = 1'b1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(700);
      test_backpressure();
      test_random(550);
      wait_drained();
      idle_on = 1'b0;
      test_random(170);

      wait (pending_q.size() == 0);
      repeat (200) @(posedge clock);
      $display("Checked %0d results: %0d ok, %0d pool full, %0d bad handle,",
               results_seen, status_seen[ffpa_pkg::ST_OK], status_seen[ffpa_pkg::ST_POOL_FULL],
               status_seen[ffpa_pkg::ST_BAD_HANDLE]);
      $display("%0d out of bounds, %0d table full; %0d table entries, bump offset %0d.",
               status_seen[ffpa_pkg::ST_OOB], status_seen[ffpa_pkg::ST_TABLE_FULL],
               blk_count, bump_ptr);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
